FILE: hdl/utf8d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_pkg
// Types and constants shared by the UTF-8 to code point decoder modules.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CP_W     = 21;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LEFT_W   = 2;
  localparam int unsigned OUT_W    = 32;

  localparam logic [BYTE_W-1:0] TOP2_MASK  = 8'b1100_0000;
  localparam logic [BYTE_W-1:0] TRAIL_TAG  = 8'b1000_0000;
  localparam logic [BYTE_W-1:0] SIX_BITS   = 8'b0011_1111;
  localparam logic [BYTE_W-1:0] FIVE_BITS  = 8'b0001_1111;
  localparam logic [BYTE_W-1:0] FOUR_BITS  = 8'b0000_1111;
  localparam logic [BYTE_W-1:0] THREE_BITS = 8'b0000_0111;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_LEAD   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_TRAIL  = 2'd2;

  typedef struct packed {
    logic [LEFT_W-1:0] trail_left;
    logic [CP_W-1:0]   partial_code;
  } dec_state_t;

  typedef struct packed {
    logic                valid;
    logic [CP_W-1:0]     code_point;
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   error_byte;
  } dec_result_t;

endpackage

FILE: hdl/utf8d_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_step
// Decode of one byte against the current sequence state: next state and
// the result the byte produces, if any.
// ----------------------------------------------------------------------------
module utf8d_step (
  input  logic [utf8d_pkg::BYTE_W-1:0] in_byte,
  input  utf8d_pkg::dec_state_t        state,
  output utf8d_pkg::dec_state_t        state_next,
  output utf8d_pkg::dec_result_t       result
);

  logic [utf8d_pkg::CP_W-1:0]   shifted;
  logic [utf8d_pkg::LEFT_W-1:0] left_dec;

  assign shifted  = {state.partial_code[utf8d_pkg::CP_W-7:0],
                     in_byte[5:0] & utf8d_pkg::SIX_BITS[5:0]};
  assign left_dec = state.trail_left - utf8d_pkg::LEFT_W'(1);

  always_comb begin
    state_next        = state;
    result.valid      = 1'b0;
    result.code_point = '0;
    result.status     = utf8d_pkg::ST_OK;
    result.error_byte = '0;
    if (state.trail_left == '0) begin
      if (in_byte[7] == 1'b0) begin
        result.valid      = 1'b1;
        result.code_point = utf8d_pkg::CP_W'(in_byte);
      end else if (in_byte[7:5] == 3'b110) begin
        state_next.partial_code = utf8d_pkg::CP_W'(in_byte & utf8d_pkg::FIVE_BITS);
        state_next.trail_left   = 2'd1;
      end else if (in_byte[7:4] == 4'b1110) begin
        state_next.partial_code = utf8d_pkg::CP_W'(in_byte & utf8d_pkg::FOUR_BITS);
        state_next.trail_left   = 2'd2;
      end else if (in_byte[7:3] == 5'b11110) begin
        state_next.partial_code = utf8d_pkg::CP_W'(in_byte & utf8d_pkg::THREE_BITS);
        state_next.trail_left   = 2'd3;
      end else begin
        // stray continuation or F8..FF
        result.valid      = 1'b1;
        result.status     = utf8d_pkg::ST_BAD_LEAD;
        result.error_byte = in_byte;
      end
    end else if ((in_byte & utf8d_pkg::TOP2_MASK) != utf8d_pkg::TRAIL_TAG) begin
      state_next.trail_left   = '0;
      state_next.partial_code = '0;
      result.valid            = 1'b1;
      result.status           = utf8d_pkg::ST_BAD_TRAIL;
      result.error_byte       = in_byte;
    end else if (left_dec == '0) begin
      state_next.trail_left   = '0;
      state_next.partial_code = '0;
      result.valid            = 1'b1;
      result.code_point       = shifted;
    end else begin
      state_next.trail_left   = left_dec;
      state_next.partial_code = shifted;
    end
  end

endmodule

FILE: hdl/utf8d_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_out_reg
// Result register on the master side; takes a new result whenever it is
// empty or its current result is being taken.
// ----------------------------------------------------------------------------
module utf8d_out_reg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  utf8d_pkg::dec_result_t        result,
  output logic                          room,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [utf8d_pkg::OUT_W-1:0]   m_tdata  // code_point, status, error_byte, pad
);

  logic                          out_valid;
  logic                          out_valid_next;
  logic [utf8d_pkg::CP_W-1:0]    code_point;
  logic [utf8d_pkg::STATUS_W-1:0] status;
  logic [utf8d_pkg::BYTE_W-1:0]  error_byte;

  assign room = !out_valid || m_tready;

  always_comb begin
    out_valid_next = out_valid;
    if (room) begin
      out_valid_next = load && result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (room && load && result.valid) begin
      code_point <= result.code_point;
      status     <= result.status;
      error_byte <= result.error_byte;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, error_byte, status, code_point};

endmodule

FILE: hdl/utf8_to_code_point_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_code_point_decoder_unit
// Datapath: an accepted byte is held in the input register and decoded
// combinationally; its result is held in the result register, which drives m_tdata.
// Throughput: one byte per cycle; input register and result register both
// advance every cycle while the master side takes results.
// Reset (rst, synchronous): empties both registers, expects a lead byte.
// ----------------------------------------------------------------------------
module utf8_to_code_point_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // in_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // code_point[20:0], status[22:21], error_byte[30:23], pad
);

  logic                           in_valid;
  logic [utf8d_pkg::BYTE_W-1:0]   in_byte;
  logic                           consume;
  logic                           room;
  utf8d_pkg::dec_state_t          state;
  utf8d_pkg::dec_state_t          state_next;
  utf8d_pkg::dec_result_t         result;

  // byte leaves the input register when it yields no result or the
  // result register can take it
  assign consume  = in_valid && (!result.valid || room);
  assign s_tready = !in_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (consume) begin
      state <= state_next;
    end
  end

  utf8d_step u_step (
    .in_byte    (in_byte),
    .state      (state),
    .state_next (state_next),
    .result     (result)
  );

  utf8d_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (consume),
    .result   (result),
    .room     (room),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

FILE: hdl/utf8d_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_checker
// Port-level checks on the decoder's result stream.
// ----------------------------------------------------------------------------
module utf8d_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[22:21] == utf8d_pkg::ST_OK ||
                 m_tdata[22:21] == utf8d_pkg::ST_BAD_LEAD ||
                 m_tdata[22:21] == utf8d_pkg::ST_BAD_TRAIL)
    else $error("illegal status code");

  a_ok_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[22:21] == utf8d_pkg::ST_OK |-> m_tdata[31:23] == '0)
    else $error("error byte set on good code point");

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[22:21] != utf8d_pkg::ST_OK |-> m_tdata[20:0] == '0)
    else $error("code point set on error result");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind utf8_to_code_point_decoder_unit utf8d_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
